[hw/rtl/assert_macros.svh]
// Concurrent assertion helpers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define DMH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge
`define DMH_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/dmh_pkg.sv]
`default_nettype none
package dmh_pkg;

   localparam int CAPACITY_DEF  = 256;
   localparam int TASK_IDS_DEF  = 256;
   localparam int MAX_ARITY_DEF = 8;

   localparam int TASK_W  = 8;
   localparam int PRI_W   = 32;
   localparam int ENTRY_W = TASK_W + PRI_W;
   localparam int COUNT_W = 9;
   localparam int CSR_W   = 4;

   localparam logic [1:0] OP_INSERT   = 2'd0;
   localparam logic [1:0] OP_EXTRACT  = 2'd1;
   localparam logic [1:0] OP_DECREASE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [CSR_W-1:0] ARITY_RESET = 4'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_CHK,
      S_UP_DIV,
      S_UP_CMP,
      S_DN_MUL,
      S_DN_RD,
      S_DN_CMP,
      S_DN_DEC,
      S_EX_TOP,
      S_EX_LAST,
      S_DK_SLOT,
      S_DK_CMP,
      S_DONE
   } dmh_state_type;

endpackage
`default_nettype wire

[hw/rtl/dmh_ram.sv]
`default_nettype none
module dmh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

[hw/rtl/dmh_div.sv]
`default_nettype none
module dmh_div #(
   parameter int W  = 8,
   parameter int DW = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [W-1:0]  dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               done,
   output logic [W-1:0]       quotient
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic [W:0]    shifted;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      diff    = trial - {1'b0, dvs_ff};
      shifted = {quo_ff, ge};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         quo_in = shifted[W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

[hw/rtl/dary_min_heap_priority_queue.sv]
// d-ary min-heap priority queue of task ids.
// Input channel req_*: opcode (insert, extract minimum, decrease key), task id
// and signed priority; one transaction per operation, taken on valid and !stall.
// Result channel rsp_*: one transaction per operation carrying status, the
// extracted task id and the entry count after the operation.
// csr_we/csr_wdata write the arity (children per node); values below 2 act as
// 2, values above MAX_ARITY as MAX_ARITY. Write only while no operation runs.
// One operation at a time: req_stall is high from acceptance until the result
// is placed in the output register. A rejected operation goes straight to the
// done state and presents its result from there; sift-up starts the shared
// restoring divider to compute each parent index and compares with the parent
// read from the slot memory, sift-down reads the children one by one through
// the read port of the slot memory (one write port, one read port).
// The output register holds a result while rsp_stall is high; the next
// operation may be accepted meanwhile and waits for the register at its end.
// Reset (synchronous) empties the queue, clears all presence flags and sets
// the arity to 2; memories need no clearing.
`default_nettype none
`include "assert_macros.svh"
module dary_min_heap_priority_queue #(
   parameter int CAPACITY  = dmh_pkg::CAPACITY_DEF,
   parameter int TASK_IDS  = dmh_pkg::TASK_IDS_DEF,
   parameter int MAX_ARITY = dmh_pkg::MAX_ARITY_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_opcode,
   input  wire logic [dmh_pkg::TASK_W-1:0]       req_task_id,
   input  wire logic signed [dmh_pkg::PRI_W-1:0] req_priority_req,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic [dmh_pkg::TASK_W-1:0]            rsp_min_task_id,
   output logic [dmh_pkg::COUNT_W-1:0]           rsp_entry_count,
   input  wire logic                             csr_we,
   input  wire logic [dmh_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ID_W   = $clog2(TASK_IDS);
   localparam int AR_W   = $clog2(MAX_ARITY + 1);
   localparam int CH_W   = SLOT_W + AR_W + 1;
   localparam int TW     = dmh_pkg::TASK_W;
   localparam int PW     = dmh_pkg::PRI_W;
   localparam int EW     = dmh_pkg::ENTRY_W;
   localparam int CSR_W_L = dmh_pkg::CSR_W;

   dmh_pkg::dmh_state_type state_ff, state_in;

   logic [CSR_W_L-1:0] arity_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TASK_IDS-1:0] present_ff, present_in;
   logic [1:0]          op_ff, op_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [PW-1:0]       pr_ff, pr_in;
   logic [TW-1:0]       cur_task_ff, cur_task_in;
   logic [PW-1:0]       cur_pri_ff, cur_pri_in;
   logic [SLOT_W-1:0]   pos_ff, pos_in;
   logic [SLOT_W-1:0]   parent_ff, parent_in;
   logic [CH_W-1:0]     base_ff, base_in;
   logic [AR_W:0]       k_ff, k_in;
   logic [SLOT_W-1:0]   best_ff, best_in;
   logic [TW-1:0]       best_task_ff, best_task_in;
   logic [PW-1:0]       best_pri_ff, best_pri_in;
   logic [1:0]          status_ff, status_in;
   logic [TW-1:0]       min_ff, min_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [TW-1:0]       rsp_min_ff, rsp_min_in;
   logic [dmh_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [AR_W-1:0]   eff_d;
   logic              accept;
   logic              id_ok;
   logic [ID_W-1:0]   req_idx;
   logic [CH_W-1:0]   child;

   logic              slot_we;
   logic [SLOT_W-1:0] slot_waddr, slot_raddr;
   logic [EW-1:0]     slot_wdata, slot_rdata;
   logic [TW-1:0]     rd_task;
   logic [PW-1:0]     rd_pri;
   logic              ts_we;
   logic [ID_W-1:0]   ts_waddr, ts_raddr;
   logic [SLOT_W-1:0] ts_wdata, ts_rdata;

   logic              div_start, div_done;
   logic [SLOT_W-1:0] div_quo;

   dmh_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   dmh_ram #(.WIDTH(SLOT_W), .DEPTH(TASK_IDS)) u_task_slot_ram (
      .clock (clock),
      .we    (ts_we),
      .waddr (ts_waddr),
      .wdata (ts_wdata),
      .raddr (ts_raddr),
      .rdata (ts_rdata)
   );

   dmh_div #(.W(SLOT_W), .DW(AR_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pos_ff - 1'b1),
      .divisor  (eff_d),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      if (arity_ff < 4'd2) begin
         eff_d = AR_W'(2);
      end else if (32'(arity_ff) > MAX_ARITY) begin
         eff_d = AR_W'(MAX_ARITY);
      end else begin
         eff_d = AR_W'(arity_ff);
      end
   end

   assign req_stall = (state_ff != dmh_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign id_ok     = 32'(req_task_id) < TASK_IDS;
   assign req_idx   = ID_W'(req_task_id);
   assign rd_task   = slot_rdata[EW-1:PW];
   assign rd_pri    = slot_rdata[PW-1:0];
   assign child     = base_ff + CH_W'(k_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      present_in    = present_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      pr_in         = pr_ff;
      cur_task_in   = cur_task_ff;
      cur_pri_in    = cur_pri_ff;
      pos_in        = pos_ff;
      parent_in     = parent_ff;
      base_in       = base_ff;
      k_in          = k_ff;
      best_in       = best_ff;
      best_task_in  = best_task_ff;
      best_pri_in   = best_pri_ff;
      status_in     = status_ff;
      min_in        = min_ff;
      rsp_valid_in  = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_count_in  = rsp_count_ff;
      slot_we       = 1'b0;
      slot_waddr    = pos_ff;
      slot_wdata    = {cur_task_ff, cur_pri_ff};
      slot_raddr    = '0;
      ts_we         = 1'b0;
      ts_waddr      = ID_W'(cur_task_ff);
      ts_wdata      = pos_ff;
      ts_raddr      = req_idx;
      div_start     = 1'b0;

      case (state_ff)
         dmh_pkg::S_IDLE: begin
            if (accept) begin
               op_in     = req_opcode;
               id_in     = req_idx;
               pr_in     = req_priority_req;
               status_in = dmh_pkg::ST_OK;
               min_in    = '0;
               case (req_opcode)
                  dmh_pkg::OP_INSERT: begin
                     if (!id_ok || present_ff[req_idx]) begin
                        status_in = dmh_pkg::ST_IGNORED;
                        state_in  = dmh_pkg::S_DONE;
                     end else if (count_ff >= CNT_W'(CAPACITY)) begin
                        status_in = dmh_pkg::ST_FULL;
                        state_in  = dmh_pkg::S_DONE;
                     end else begin
                        present_in[req_idx] = 1'b1;
                        count_in    = count_ff + 1'b1;
                        cur_task_in = req_task_id;
                        cur_pri_in  = req_priority_req;
                        pos_in      = SLOT_W'(count_ff);
                        state_in    = dmh_pkg::S_UP_CHK;
                     end
                  end
                  dmh_pkg::OP_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = dmh_pkg::ST_EMPTY;
                        state_in  = dmh_pkg::S_DONE;
                     end else begin
                        slot_raddr = '0;
                        state_in   = dmh_pkg::S_EX_TOP;
                     end
                  end
                  dmh_pkg::OP_DECREASE: begin
                     if (!id_ok || !present_ff[req_idx]) begin
                        status_in = dmh_pkg::ST_IGNORED;
                        state_in  = dmh_pkg::S_DONE;
                     end else begin
                        ts_raddr = req_idx;
                        state_in = dmh_pkg::S_DK_SLOT;
                     end
                  end
                  default: begin
                     state_in = dmh_pkg::S_DONE;
                  end
               endcase
            end
         end
         dmh_pkg::S_EX_TOP: begin
            min_in = rd_task;
            present_in[ID_W'(rd_task)] = 1'b0;
            count_in   = count_ff - 1'b1;
            slot_raddr = SLOT_W'(count_ff - 1'b1);
            state_in   = (count_ff == CNT_W'(1)) ? dmh_pkg::S_DONE : dmh_pkg::S_EX_LAST;
         end
         dmh_pkg::S_EX_LAST: begin
            cur_task_in = rd_task;
            cur_pri_in  = rd_pri;
            pos_in      = '0;
            state_in    = dmh_pkg::S_DN_MUL;
         end
         dmh_pkg::S_DK_SLOT: begin
            pos_in     = ts_rdata;
            slot_raddr = ts_rdata;
            if (32'(ts_rdata) >= 32'(count_ff)) begin
               status_in = dmh_pkg::ST_IGNORED;
               state_in  = dmh_pkg::S_DONE;
            end else begin
               state_in = dmh_pkg::S_DK_CMP;
            end
         end
         dmh_pkg::S_DK_CMP: begin
            if ($signed(pr_ff) < $signed(rd_pri)) begin
               cur_task_in = rd_task;
               cur_pri_in  = pr_ff;
               state_in    = dmh_pkg::S_UP_CHK;
            end else begin
               status_in = dmh_pkg::ST_IGNORED;
               state_in  = dmh_pkg::S_DONE;
            end
         end
         dmh_pkg::S_UP_CHK: begin
            if (pos_ff == '0) begin
               slot_we  = 1'b1;
               ts_we    = 1'b1;
               state_in = dmh_pkg::S_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = dmh_pkg::S_UP_DIV;
            end
         end
         dmh_pkg::S_UP_DIV: begin
            slot_raddr = div_quo;
            if (div_done) begin
               parent_in = div_quo;
               state_in  = dmh_pkg::S_UP_CMP;
            end
         end
         dmh_pkg::S_UP_CMP: begin
            slot_we = 1'b1;
            ts_we   = 1'b1;
            if ($signed(cur_pri_ff) < $signed(rd_pri)) begin
               slot_wdata = slot_rdata;
               ts_waddr   = ID_W'(rd_task);
               pos_in     = parent_ff;
               state_in   = dmh_pkg::S_UP_CHK;
            end else begin
               state_in = dmh_pkg::S_DONE;
            end
         end
         dmh_pkg::S_DN_MUL: begin
            base_in      = CH_W'(eff_d) * CH_W'(pos_ff);
            k_in         = (AR_W + 1)'(1);
            best_in      = pos_ff;
            best_task_in = cur_task_ff;
            best_pri_in  = cur_pri_ff;
            state_in     = dmh_pkg::S_DN_RD;
         end
         dmh_pkg::S_DN_RD: begin
            slot_raddr = child[SLOT_W-1:0];
            if (k_ff > (AR_W + 1)'(eff_d) || child >= CH_W'(count_ff)) begin
               state_in = dmh_pkg::S_DN_DEC;
            end else begin
               state_in = dmh_pkg::S_DN_CMP;
            end
         end
         dmh_pkg::S_DN_CMP: begin
            if ($signed(rd_pri) < $signed(best_pri_ff)) begin
               best_in      = child[SLOT_W-1:0];
               best_task_in = rd_task;
               best_pri_in  = rd_pri;
            end
            k_in     = k_ff + 1'b1;
            state_in = dmh_pkg::S_DN_RD;
         end
         dmh_pkg::S_DN_DEC: begin
            slot_we = 1'b1;
            ts_we   = 1'b1;
            if (best_ff == pos_ff) begin
               state_in = dmh_pkg::S_DONE;
            end else begin
               slot_wdata = {best_task_ff, best_pri_ff};
               ts_waddr   = ID_W'(best_task_ff);
               pos_in     = best_ff;
               state_in   = dmh_pkg::S_DN_MUL;
            end
         end
         dmh_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_min_in    = min_ff;
               rsp_count_in  = dmh_pkg::COUNT_W'(count_ff);
               state_in      = dmh_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dmh_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dmh_pkg::S_IDLE;
         arity_ff     <= dmh_pkg::ARITY_RESET;
         count_ff     <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            arity_ff <= csr_wdata;
         end
      end
      op_ff         <= op_in;
      id_ff         <= id_in;
      pr_ff         <= pr_in;
      cur_task_ff   <= cur_task_in;
      cur_pri_ff    <= cur_pri_in;
      pos_ff        <= pos_in;
      parent_ff     <= parent_in;
      base_ff       <= base_in;
      k_ff          <= k_in;
      best_ff       <= best_in;
      best_task_ff  <= best_task_in;
      best_pri_ff   <= best_pri_in;
      status_ff     <= status_in;
      min_ff        <= min_in;
      rsp_status_ff <= rsp_status_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_min_task_id = rsp_min_ff;
   assign rsp_entry_count = rsp_count_ff;

   `DMH_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `DMH_ASSERT(a_parent_below, clock, reset, (state_ff == dmh_pkg::S_UP_CMP) |-> (parent_ff < pos_ff), "parent index not below node")
   `DMH_ASSERT(a_empty_count, clock, reset, (rsp_valid_ff && rsp_status_ff == dmh_pkg::ST_EMPTY) |-> (rsp_count_ff == '0), "empty status with entries")
   `DMH_ASSERT(a_ext_id_used, clock, reset, (state_ff == dmh_pkg::S_DK_CMP) |-> (op_ff == dmh_pkg::OP_DECREASE && present_ff[id_ff]), "decrease of absent task")

endmodule
`default_nettype wire

[bench/dmh_checker.sv]
`default_nettype none
module dmh_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire logic [1:0]                       req_opcode,
   input  wire logic [dmh_pkg::TASK_W-1:0]       req_task_id,
   input  wire logic signed [dmh_pkg::PRI_W-1:0] req_priority_req,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire logic [1:0]                       rsp_status,
   input  wire logic [dmh_pkg::TASK_W-1:0]       rsp_min_task_id,
   input  wire logic [dmh_pkg::COUNT_W-1:0]      rsp_entry_count,
   input  wire logic                             csr_we,
   input  wire logic [dmh_pkg::CSR_W-1:0]        csr_wdata,
   output int                                    fail_count,
   output int                                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]                  status;
      logic [dmh_pkg::TASK_W-1:0]  min_id;
      logic [dmh_pkg::COUNT_W-1:0] entries;
   } heap_result_type;

   logic [dmh_pkg::TASK_W-1:0]       heap_task [256];
   logic signed [dmh_pkg::PRI_W-1:0] heap_pri  [256];
   int                               slot_of   [256];
   bit                               queued    [256];
   int                               entries;
   logic [dmh_pkg::CSR_W-1:0]        arity_reg;
   heap_result_type                  awaited [$];

   function automatic int fanout();
      if (arity_reg < 2) return 2;
      if (arity_reg > dmh_pkg::MAX_ARITY_DEF) return dmh_pkg::MAX_ARITY_DEF;
      return int'(arity_reg);
   endfunction

   function automatic void swap_nodes(int a, int b);
      logic [dmh_pkg::TASK_W-1:0]       t;
      logic signed [dmh_pkg::PRI_W-1:0] p;
      t = heap_task[a]; p = heap_pri[a];
      heap_task[a] = heap_task[b]; heap_pri[a] = heap_pri[b];
      heap_task[b] = t; heap_pri[b] = p;
      slot_of[heap_task[a]] = a;
      slot_of[heap_task[b]] = b;
   endfunction

   function automatic void bubble_up(int pos);
      int d;
      int up;
      d = fanout();
      while (pos > 0 && pos < entries) begin
         up = (pos - 1) / d;
         if (!(heap_pri[pos] < heap_pri[up])) break;
         swap_nodes(pos, up);
         pos = up;
      end
   endfunction

   function automatic void push_down(int pos);
      int d;
      int best;
      int c;
      d = fanout();
      while (pos < entries) begin
         best = pos;
         for (int k = 1; k <= d; k++) begin
            c = d * pos + k;
            if (c < entries && heap_pri[c] < heap_pri[best]) best = c;
         end
         if (best == pos) break;
         swap_nodes(pos, best);
         pos = best;
      end
   endfunction

   function automatic heap_result_type apply_op(logic [1:0] op,
                                                logic [dmh_pkg::TASK_W-1:0] id,
                                                logic signed [dmh_pkg::PRI_W-1:0] pri);
      heap_result_type r;
      int              pos;
      r = '0;
      if (op == dmh_pkg::OP_INSERT) begin
         if (queued[id]) r.status = dmh_pkg::ST_IGNORED;
         else if (entries >= dmh_pkg::CAPACITY_DEF) r.status = dmh_pkg::ST_FULL;
         else begin
            pos = entries;
            heap_task[pos] = id;
            heap_pri[pos] = pri;
            slot_of[id] = pos;
            queued[id] = 1'b1;
            entries++;
            bubble_up(pos);
         end
      end else if (op == dmh_pkg::OP_EXTRACT) begin
         if (entries == 0) r.status = dmh_pkg::ST_EMPTY;
         else begin
            r.min_id = heap_task[0];
            queued[heap_task[0]] = 1'b0;
            entries--;
            if (entries > 0) begin
               heap_task[0] = heap_task[entries];
               heap_pri[0] = heap_pri[entries];
               slot_of[heap_task[0]] = 0;
               push_down(0);
            end
         end
      end else if (op == dmh_pkg::OP_DECREASE) begin
         if (!queued[id]) r.status = dmh_pkg::ST_IGNORED;
         else begin
            pos = slot_of[id];
            if (pos >= entries || !(pri < heap_pri[pos])) r.status = dmh_pkg::ST_IGNORED;
            else begin
               heap_pri[pos] = pri;
               bubble_up(pos);
            end
         end
      end
      r.entries = dmh_pkg::COUNT_W'(entries);
      return r;
   endfunction

   assign pending = awaited.size();

   always @(posedge clock) begin
      heap_result_type want;
      if (reset) begin
         for (int i = 0; i < 256; i++) queued[i] = 1'b0;
         entries = 0;
         arity_reg = dmh_pkg::ARITY_RESET;
         awaited.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               $display("%0t: result with none awaited: status %0d id %0d count %0d",
                        $time, rsp_status, rsp_min_task_id, rsp_entry_count);
               fail_count <= fail_count + 1;
            end else begin
               want = awaited.pop_front();
               if (want.status !== rsp_status || want.min_id !== rsp_min_task_id ||
                   want.entries !== rsp_entry_count) begin
                  $display("%0t: expected status %0d id %0d count %0d, got %0d %0d %0d",
                           $time, want.status, want.min_id, want.entries,
                           rsp_status, rsp_min_task_id, rsp_entry_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            awaited.insert(awaited.size(),
                           apply_op(req_opcode, req_task_id, req_priority_req));
         if (csr_we) arity_reg = csr_wdata;
      end
   end
endmodule
`default_nettype wire

[bench/tb_dary_min_heap_priority_queue.sv]
`default_nettype none
module tb_dary_min_heap_priority_queue;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_SPARE = 2'd3;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [1:0]                       req_opcode = dmh_pkg::OP_INSERT;
   logic [dmh_pkg::TASK_W-1:0]       req_task_id = '0;
   logic signed [dmh_pkg::PRI_W-1:0] req_priority_req = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [1:0]                       rsp_status;
   logic [dmh_pkg::TASK_W-1:0]       rsp_min_task_id;
   logic [dmh_pkg::COUNT_W-1:0]      rsp_entry_count;
   logic                             csr_we = 1'b0;
   logic [dmh_pkg::CSR_W-1:0]        csr_wdata = '0;
   int                               fail_count;
   int                               pending;
   int                               cycles = 0;
   bit                               calm = 1'b0;
   int                               sink_wait = 0;

   always #10 clock = ~clock;

   dary_min_heap_priority_queue DUT (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_task_id,
      .req_priority_req, .rsp_valid, .rsp_stall, .rsp_status, .rsp_min_task_id,
      .rsp_entry_count, .csr_we, .csr_wdata
   );

   dmh_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_task_id,
      .req_priority_req, .rsp_valid, .rsp_stall, .rsp_status, .rsp_min_task_id,
      .rsp_entry_count, .csr_we, .csr_wdata, .fail_count, .pending
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("tb_dary_min_heap_priority_queue: errors");
         $finish;
      end
   end

   // hold the result channel for a randomly drawn wait after each transaction, unless calm is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         sink_wait <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         sink_wait <= calm ? 0 : $urandom_range(0, 18);
         rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 18) > 4);
      end else if (sink_wait > 0) begin
         sink_wait <= sink_wait - 1;
         rsp_stall <= (sink_wait > 1);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send(logic [1:0] op, logic [dmh_pkg::TASK_W-1:0] id,
                       logic [dmh_pkg::PRI_W-1:0] pri);
      int  gap;
      bit  stalled;
      gap = calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_task_id <= id;
      req_priority_req <= pri;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_arity(logic [dmh_pkg::CSR_W-1:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [dmh_pkg::PRI_W-1:0] pick_pri();
      if ($urandom_range(0, 1)) return dmh_pkg::PRI_W'($urandom_range(0, 1000)) - 500;
      return $urandom;
   endfunction

   task automatic churn(int n, logic [dmh_pkg::TASK_W-1:0] id_mask);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45)
            send(dmh_pkg::OP_INSERT, dmh_pkg::TASK_W'($urandom) & id_mask, pick_pri());
         else if (r < 75)
            send(dmh_pkg::OP_EXTRACT, dmh_pkg::TASK_W'($urandom), $urandom);
         else if (r < 96)
            send(dmh_pkg::OP_DECREASE, dmh_pkg::TASK_W'($urandom) & id_mask, pick_pri());
         else
            send(OP_SPARE, dmh_pkg::TASK_W'($urandom), $urandom);
      end
   endtask

   initial begin
      int order [256];
      int j;
      int t;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(dmh_pkg::OP_EXTRACT, 8'd0, 32'd0);
      send(dmh_pkg::OP_INSERT, 8'd0, 32'h8000_0000);
      send(dmh_pkg::OP_INSERT, 8'd255, 32'h7fff_ffff);
      send(dmh_pkg::OP_INSERT, 8'd0, 32'd5);
      send(dmh_pkg::OP_DECREASE, 8'd7, 32'd0);
      send(dmh_pkg::OP_DECREASE, 8'd255, 32'h7fff_ffff);
      send(dmh_pkg::OP_DECREASE, 8'd255, 32'h8000_0000);
      send(OP_SPARE, 8'hff, 32'hffff_ffff);
      send(dmh_pkg::OP_EXTRACT, 8'd0, 32'd0);
      send(dmh_pkg::OP_EXTRACT, 8'd0, 32'd0);
      send(dmh_pkg::OP_EXTRACT, 8'd0, 32'd0);
      send(dmh_pkg::OP_INSERT, 8'd170, 32'h5555_5555);
      send(dmh_pkg::OP_INSERT, 8'd85, 32'haaaa_aaaa);
      send(dmh_pkg::OP_DECREASE, 8'd170, 32'haaaa_aaaa);
      send(dmh_pkg::OP_EXTRACT, 8'd0, 32'd0);
      send(dmh_pkg::OP_EXTRACT, 8'd0, 32'd0);

      set_arity(4'd8);
      churn(250, 8'h0f);
      set_arity(4'd0);
      churn(250, 8'hff);
      calm = 1'b1;
      set_arity(4'd15);
      churn(200, 8'h1f);
      calm = 1'b0;
      set_arity(4'd3);

      for (int i = 0; i < 256; i++) order[i] = i;
      for (int i = 255; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = order[i]; order[i] = order[j]; order[j] = t;
      end
      for (int i = 0; i < 256; i++)
         send(dmh_pkg::OP_INSERT, dmh_pkg::TASK_W'(order[i]), pick_pri());
      send(dmh_pkg::OP_INSERT, dmh_pkg::TASK_W'(order[0]), 32'd0);
      churn(40, 8'hff);
      for (int i = 0; i < 258; i++) send(dmh_pkg::OP_EXTRACT, 8'd0, 32'd0);

      set_arity(4'd1);
      churn(250, 8'h3f);
      set_arity(4'd5);
      churn(250, 8'h07);
      set_arity(4'd2);
      churn(200, 8'hff);

      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_dary_min_heap_priority_queue: clean");
      end else begin
         $display("tb_dary_min_heap_priority_queue: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
